[hdl/llt_pkg.sv]
package llt_pkg;

	// field widths and fixed-point positions
	localparam int M_W     = 24;   // magnetization, Q1.22
	localparam int F_W     = 32;   // field, drift vector and current, Q16.16
	localparam int CFG_W   = 16;   // widest register, alpha and beta in Q0.16
	localparam int MODE_W  = 2;
	localparam int IDX_W   = 2;
	localparam int OUT_W   = 48;
	localparam int FRAC_M  = 22;
	localparam int FRAC_F  = 16;

	// derived widths of the intermediate values
	localparam int P_W     = M_W + F_W + 1 - FRAC_M;    // m x h, m x u
	localparam int D_W     = M_W + P_W + 1 - FRAC_M;    // m x (m x h), m x (m x u)
	localparam int K1_W    = CFG_W + 1;                 // beta - alpha, signed
	localparam int K2_W    = CFG_W + 2;                 // 1 + alpha*beta, unsigned
	localparam int DPR_W   = CFG_W + 1 + D_W;
	localparam int DAMP_W  = DPR_W - FRAC_F;
	localparam int T1PR_W  = K1_W + P_W;
	localparam int T1_W    = T1PR_W - FRAC_F;
	localparam int T2PR_W  = K2_W + 1 + D_W;
	localparam int T2_W    = T2PR_W - FRAC_F;
	localparam int BASE_W  = DAMP_W + 2;
	localparam int S_W     = T2_W + 1;
	localparam int ABS_W   = S_W - 1;
	localparam int SPLIT_W = 32;
	localparam int HI_W    = ABS_W - SPLIT_W;
	localparam int LO_W    = SPLIT_W + F_W;
	localparam int HIP_W   = HI_W + F_W;
	localparam int MAG_W   = HIP_W + FRAC_F + 1;
	localparam int SUM_W   = MAG_W + 2;

	localparam int NSTAGE  = 10;

	localparam int HALF_F  = 1 << (FRAC_F - 1);
	localparam int ONE_F   = 1 << FRAC_F;

	localparam logic [MODE_W-1:0] MODE_DAMP    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLASSIC = 2'd1;
	localparam logic [MODE_W-1:0] MODE_STT     = 2'd2;

	localparam logic [IDX_W-1:0] REG_MODE         = 2'd0;
	localparam logic [IDX_W-1:0] REG_DAMPING      = 2'd1;
	localparam logic [IDX_W-1:0] REG_NONADIABATIC = 2'd2;

	localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [CFG_W-1:0]  alpha;
		logic [K1_W-1:0]   k1;
		logic [K2_W-1:0]   k2;
	} coef_t;

endpackage

[hdl/llt_if.sv]
interface llt_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [llt_pkg::M_W-1:0]      mag_x;
	logic signed [llt_pkg::M_W-1:0]      mag_y;
	logic signed [llt_pkg::M_W-1:0]      mag_z;
	logic signed [llt_pkg::F_W-1:0]      field_x;
	logic signed [llt_pkg::F_W-1:0]      field_y;
	logic signed [llt_pkg::F_W-1:0]      field_z;
	logic signed [llt_pkg::F_W-1:0]      spin_u_x;
	logic signed [llt_pkg::F_W-1:0]      spin_u_y;
	logic signed [llt_pkg::F_W-1:0]      spin_u_z;
	logic signed [llt_pkg::F_W-1:0]      drive_current;

	modport source (
		output valid, mag_x, mag_y, mag_z, field_x, field_y, field_z,
		       spin_u_x, spin_u_y, spin_u_z, drive_current,
		input  ready
	);
	modport sink (
		input  valid, mag_x, mag_y, mag_z, field_x, field_y, field_z,
		       spin_u_x, spin_u_y, spin_u_z, drive_current,
		output ready
	);
endinterface

interface llt_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [llt_pkg::OUT_W-1:0]    rate_x;
	logic signed [llt_pkg::OUT_W-1:0]    rate_y;
	logic signed [llt_pkg::OUT_W-1:0]    rate_z;

	modport source (output valid, rate_x, rate_y, rate_z, input ready);
	modport sink (input valid, rate_x, rate_y, rate_z, output ready);
endinterface

[hdl/llt_coef.sv]
module llt_coef (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [llt_pkg::IDX_W-1:0]      cfg_index,
	input  logic [llt_pkg::CFG_W-1:0]      cfg_data,
	output llt_pkg::coef_t                 coef
);

	localparam int AB_W  = 2 * llt_pkg::CFG_W;
	localparam int ABR_W = AB_W + 1;

	logic [llt_pkg::MODE_W-1:0] mode_q;
	logic [llt_pkg::CFG_W-1:0]  alpha_q;
	logic [llt_pkg::CFG_W-1:0]  beta_q;
	logic [llt_pkg::K1_W-1:0]   k1_q;
	logic [llt_pkg::K2_W-1:0]   k2_q;
	logic [AB_W-1:0]            ab;
	logic [ABR_W-1:0]           ab_rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= llt_pkg::MODE_CLASSIC;
			alpha_q <= '0;
			beta_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				llt_pkg::REG_MODE:         mode_q  <= cfg_data[llt_pkg::MODE_W-1:0];
				llt_pkg::REG_DAMPING:      alpha_q <= cfg_data;
				llt_pkg::REG_NONADIABATIC: beta_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// alpha*beta rounded to Q.16
	assign ab     = alpha_q * beta_q;
	assign ab_rnd = {1'b0, ab} + ABR_W'(llt_pkg::HALF_F);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k1_q <= '0;
			k2_q <= llt_pkg::K2_W'(llt_pkg::ONE_F);
		end else begin
			k1_q <= llt_pkg::K1_W'(beta_q) - llt_pkg::K1_W'(alpha_q);
			k2_q <= llt_pkg::K2_W'(llt_pkg::ONE_F)
			      + llt_pkg::K2_W'(ab_rnd[ABR_W-1:llt_pkg::FRAC_F]);
		end
	end

	assign coef.mode  = mode_q;
	assign coef.alpha = alpha_q;
	assign coef.k1    = k1_q;
	assign coef.k2    = k2_q;

endmodule

[hdl/llt_cross.sv]
module llt_cross #(
	parameter int B_W = llt_pkg::F_W
) (
	input  logic                                clk,
	input  logic                                en_mul,
	input  logic                                en_rnd,
	input  logic signed [llt_pkg::M_W-1:0]      a [3],
	input  logic signed [B_W-1:0]               b [3],
	output logic signed [llt_pkg::M_W+B_W-llt_pkg::FRAC_M:0] res_s2 [3]
);

	localparam int PR_W = llt_pkg::M_W + B_W;
	localparam int R_W  = PR_W + 1 - llt_pkg::FRAC_M;
	localparam logic signed [PR_W:0] HALF =
		{{(PR_W+1-llt_pkg::FRAC_M){1'b0}}, 1'b1, {(llt_pkg::FRAC_M-1){1'b0}}};

	logic signed [PR_W-1:0] prod_a_s1 [3];
	logic signed [PR_W-1:0] prod_b_s1 [3];

	for (genvar j = 0; j < 3; j++) begin : g_comp
		localparam int J1 = (j + 1) % 3;
		localparam int J2 = (j + 2) % 3;

		logic signed [PR_W:0] dif;
		logic signed [PR_W:0] sum;

		always_ff @(posedge clk) begin
			if (en_mul) begin
				prod_a_s1[j] <= a[J1] * b[J2];
				prod_b_s1[j] <= a[J2] * b[J1];
			end
		end

		assign dif = (PR_W+1)'(prod_a_s1[j]) - (PR_W+1)'(prod_b_s1[j]);
		assign sum = dif + HALF;

		// round half up, drop the Q.22 fraction of m
		always_ff @(posedge clk) begin
			if (en_rnd) begin
				res_s2[j] <= sum[PR_W:llt_pkg::FRAC_M];
			end
		end

		if (R_W != PR_W + 1 - llt_pkg::FRAC_M) begin : g_bad
			$error("cross width mismatch");
		end
	end

endmodule

[hdl/llt_scale.sv]
module llt_scale (
	input  logic                                  clk,
	input  logic [1:0]                            en,
	input  llt_pkg::coef_t                        coef,
	input  logic signed [llt_pkg::P_W-1:0]        p [3],
	input  logic signed [llt_pkg::P_W-1:0]        q [3],
	input  logic signed [llt_pkg::D_W-1:0]        d [3],
	input  logic signed [llt_pkg::D_W-1:0]        e [3],
	output logic signed [llt_pkg::BASE_W-1:0]     base_s6 [3],
	output logic signed [llt_pkg::S_W-1:0]        s_s6 [3]
);

	localparam int DPR_W  = llt_pkg::DPR_W;
	localparam int T1PR_W = llt_pkg::T1PR_W;
	localparam int T2PR_W = llt_pkg::T2PR_W;

	logic signed [DPR_W-1:0]        damp_pr_s5 [3];
	logic signed [T1PR_W-1:0]       t1_pr_s5 [3];
	logic signed [T2PR_W-1:0]       t2_pr_s5 [3];
	logic signed [llt_pkg::P_W-1:0] p_s5 [3];

	logic signed [llt_pkg::CFG_W:0] alpha_sg;
	logic signed [llt_pkg::K1_W-1:0] k1_sg;
	logic signed [llt_pkg::K2_W:0]  k2_sg;

	assign alpha_sg = $signed({1'b0, coef.alpha});
	assign k1_sg    = $signed(coef.k1);
	assign k2_sg    = $signed({1'b0, coef.k2});

	for (genvar j = 0; j < 3; j++) begin : g_comp
		logic signed [DPR_W-1:0]            damp_sum;
		logic signed [T1PR_W-1:0]           t1_sum;
		logic signed [T2PR_W-1:0]           t2_sum;
		logic signed [llt_pkg::DAMP_W-1:0]  damp;
		logic signed [llt_pkg::T1_W-1:0]    t1;
		logic signed [llt_pkg::T2_W-1:0]    t2;
		logic signed [llt_pkg::BASE_W-1:0]  base;

		always_ff @(posedge clk) begin
			if (en[0]) begin
				damp_pr_s5[j] <= alpha_sg * d[j];
				t1_pr_s5[j]   <= k1_sg * q[j];
				t2_pr_s5[j]   <= k2_sg * e[j];
				p_s5[j]       <= p[j];
			end
		end

		assign damp_sum = damp_pr_s5[j] + DPR_W'(llt_pkg::HALF_F);
		assign t1_sum   = t1_pr_s5[j] + T1PR_W'(llt_pkg::HALF_F);
		assign t2_sum   = t2_pr_s5[j] + T2PR_W'(llt_pkg::HALF_F);
		assign damp     = damp_sum[DPR_W-1:llt_pkg::FRAC_F];
		assign t1       = t1_sum[T1PR_W-1:llt_pkg::FRAC_F];
		assign t2       = t2_sum[T2PR_W-1:llt_pkg::FRAC_F];

		always_comb begin
			case (coef.mode)
				llt_pkg::MODE_DAMP: base = -llt_pkg::BASE_W'(damp);
				default:            base = -llt_pkg::BASE_W'(p_s5[j])
				                           - llt_pkg::BASE_W'(damp);
			endcase
		end

		always_ff @(posedge clk) begin
			if (en[1]) begin
				base_s6[j] <= base;
				s_s6[j]    <= -llt_pkg::S_W'(t1) - llt_pkg::S_W'(t2);
			end
		end
	end

endmodule

[hdl/llt_stt.sv]
module llt_stt (
	input  logic                                  clk,
	input  logic [3:0]                            en,
	input  llt_pkg::coef_t                        coef,
	input  logic signed [llt_pkg::BASE_W-1:0]     base [3],
	input  logic signed [llt_pkg::S_W-1:0]        s [3],
	input  logic signed [llt_pkg::F_W-1:0]        cur,
	output logic signed [llt_pkg::OUT_W-1:0]      res_s10 [3]
);

	localparam int ABS_W = llt_pkg::ABS_W;
	localparam int LOR_W = llt_pkg::LO_W + 1;
	localparam int SUM_W = llt_pkg::SUM_W;

	logic [llt_pkg::F_W-1:0] abs_i_s7;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			abs_i_s7 <= cur[llt_pkg::F_W-1] ? llt_pkg::F_W'(-cur) : llt_pkg::F_W'(cur);
		end
	end

	for (genvar j = 0; j < 3; j++) begin : g_comp
		logic [ABS_W-1:0]                   abs_s_s7;
		logic                               neg_s7, neg_s8, neg_s9;
		logic signed [llt_pkg::BASE_W-1:0]  base_s7, base_s8, base_s9;
		logic [llt_pkg::LO_W-1:0]           lo_s8;
		logic [llt_pkg::HIP_W-1:0]          hi_s8;
		logic [llt_pkg::MAG_W-1:0]          mag_s9;
		logic [LOR_W-1:0]                   lo_rnd;
		logic signed [SUM_W-1:0]            mag_ext;
		logic signed [SUM_W-1:0]            term;
		logic signed [SUM_W-1:0]            sum;
		logic signed [llt_pkg::OUT_W-1:0]   sat;

		// sign and magnitude split
		always_ff @(posedge clk) begin
			if (en[0]) begin
				abs_s_s7 <= s[j][llt_pkg::S_W-1] ? ABS_W'(-s[j]) : ABS_W'(s[j]);
				neg_s7   <= s[j][llt_pkg::S_W-1] ^ cur[llt_pkg::F_W-1];
				base_s7  <= base[j];
			end
		end

		// partial products of the magnitude, low and high slice
		always_ff @(posedge clk) begin
			if (en[1]) begin
				lo_s8   <= abs_s_s7[llt_pkg::SPLIT_W-1:0] * abs_i_s7;
				hi_s8   <= abs_s_s7[ABS_W-1:llt_pkg::SPLIT_W] * abs_i_s7;
				neg_s8  <= neg_s7;
				base_s8 <= base_s7;
			end
		end

		assign lo_rnd = {1'b0, lo_s8} + LOR_W'(llt_pkg::HALF_F);

		always_ff @(posedge clk) begin
			if (en[2]) begin
				mag_s9  <= llt_pkg::MAG_W'({hi_s8, {llt_pkg::FRAC_F{1'b0}}})
				         + llt_pkg::MAG_W'(lo_rnd[LOR_W-1:llt_pkg::FRAC_F]);
				neg_s9  <= neg_s8;
				base_s9 <= base_s8;
			end
		end

		assign mag_ext = $signed({2'b00, mag_s9});

		always_comb begin
			if (coef.mode == llt_pkg::MODE_STT) begin
				term = neg_s9 ? -mag_ext : mag_ext;
			end else begin
				term = '0;
			end
		end

		assign sum = SUM_W'(base_s9) + term;

		// saturate to 48 bits
		always_comb begin
			if ((&sum[SUM_W-1:llt_pkg::OUT_W-1]) || !(|sum[SUM_W-1:llt_pkg::OUT_W-1])) begin
				sat = sum[llt_pkg::OUT_W-1:0];
			end else if (sum[SUM_W-1]) begin
				sat = llt_pkg::OUT_MIN;
			end else begin
				sat = llt_pkg::OUT_MAX;
			end
		end

		always_ff @(posedge clk) begin
			if (en[3]) begin
				res_s10[j] <= sat;
			end
		end
	end

endmodule

[hdl/llg_torque_per_node.sv]
// LLG torque per mesh node: each request carries m (Q1.22), the effective field H,
// the spin-torque drift vector u and the drive current (all Q16.16), and yields one
// dm/dt result in Q32.16, saturated to 48 bits per component. The mode register picks
// damping only, classic LLG, or LLG plus Zhang-Li spin-transfer torque (code 3 acts as
// classic). The datapath is a ten-stage pipeline built around its multiplier stages:
// two cross products in series, a coefficient multiply, and a split 41x32 current
// multiply. It takes one node every cycle while the pipeline has room. Each stage holds
// a valid bit and advances when the stage after it is empty or moving, so a stalled
// output only blocks input once all ten stages are full. Register writes are meant for
// an idle pipeline; the derived coefficients (beta - alpha and 1 + alpha*beta) settle
// in the cycle after a write.
module llg_torque_per_node (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [llt_pkg::IDX_W-1:0]     cfg_index,
	input  logic [llt_pkg::CFG_W-1:0]     cfg_data,
	llt_in_if.sink                        node,
	llt_out_if.source                     torque
);

	localparam int NSTAGE = llt_pkg::NSTAGE;

	llt_pkg::coef_t coef;

	// per-stage valid bits and advance enables
	logic [NSTAGE:1] stage_vld_q;
	logic [NSTAGE:1] adv;

	// input fields regrouped as vectors
	logic signed [llt_pkg::M_W-1:0] mag_in   [3];
	logic signed [llt_pkg::F_W-1:0] field_in [3];
	logic signed [llt_pkg::F_W-1:0] u_in     [3];

	// side paths that run next to the cross-product units
	logic signed [llt_pkg::M_W-1:0] m_s1 [3];
	logic signed [llt_pkg::M_W-1:0] m_s2 [3];
	logic signed [llt_pkg::P_W-1:0] p_s2 [3];
	logic signed [llt_pkg::P_W-1:0] q_s2 [3];
	logic signed [llt_pkg::P_W-1:0] p_s3 [3];
	logic signed [llt_pkg::P_W-1:0] q_s3 [3];
	logic signed [llt_pkg::P_W-1:0] p_s4 [3];
	logic signed [llt_pkg::P_W-1:0] q_s4 [3];
	logic signed [llt_pkg::D_W-1:0] d_s4 [3];
	logic signed [llt_pkg::D_W-1:0] e_s4 [3];
	logic signed [llt_pkg::F_W-1:0] cur_s1, cur_s2, cur_s3, cur_s4, cur_s5, cur_s6;

	logic signed [llt_pkg::BASE_W-1:0] base_s6 [3];
	logic signed [llt_pkg::S_W-1:0]    s_s6 [3];
	logic signed [llt_pkg::OUT_W-1:0]  res_s10 [3];

	// configuration registers and derived coefficients
	llt_coef u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	always_comb begin
		mag_in[0]   = node.mag_x;
		mag_in[1]   = node.mag_y;
		mag_in[2]   = node.mag_z;
		field_in[0] = node.field_x;
		field_in[1] = node.field_y;
		field_in[2] = node.field_z;
		u_in[0]     = node.spin_u_x;
		u_in[1]     = node.spin_u_y;
		u_in[2]     = node.spin_u_z;
	end

	// a stage loads when it is empty or its content moves on; the last stage is
	// the output register
	always_comb begin
		adv[NSTAGE] = !stage_vld_q[NSTAGE] || torque.ready;
		for (int k = NSTAGE - 1; k >= 1; k--) begin
			adv[k] = !stage_vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (adv[1]) begin
				stage_vld_q[1] <= node.valid;
			end
			for (int k = 2; k <= NSTAGE; k++) begin
				if (adv[k]) begin
					stage_vld_q[k] <= stage_vld_q[k-1];
				end
			end
		end
	end

	assign node.ready = adv[1];

	// stages 1-2: p = m x H and q = m x u
	llt_cross #(.B_W(llt_pkg::F_W)) u_cross_mh (
		.clk    (clk),
		.en_mul (adv[1]),
		.en_rnd (adv[2]),
		.a      (mag_in),
		.b      (field_in),
		.res_s2 (p_s2)
	);

	llt_cross #(.B_W(llt_pkg::F_W)) u_cross_mu (
		.clk    (clk),
		.en_mul (adv[1]),
		.en_rnd (adv[2]),
		.a      (mag_in),
		.b      (u_in),
		.res_s2 (q_s2)
	);

	// stages 3-4: d = m x p and e = m x q
	llt_cross #(.B_W(llt_pkg::P_W)) u_cross_mp (
		.clk    (clk),
		.en_mul (adv[3]),
		.en_rnd (adv[4]),
		.a      (m_s2),
		.b      (p_s2),
		.res_s2 (d_s4)
	);

	llt_cross #(.B_W(llt_pkg::P_W)) u_cross_mq (
		.clk    (clk),
		.en_mul (adv[3]),
		.en_rnd (adv[4]),
		.a      (m_s2),
		.b      (q_s2),
		.res_s2 (e_s4)
	);

	// m, p, q and current follow their item down the pipe
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			m_s1   <= mag_in;
			cur_s1 <= node.drive_current;
		end
		if (adv[2]) begin
			m_s2   <= m_s1;
			cur_s2 <= cur_s1;
		end
		if (adv[3]) begin
			p_s3   <= p_s2;
			q_s3   <= q_s2;
			cur_s3 <= cur_s2;
		end
		if (adv[4]) begin
			p_s4   <= p_s3;
			q_s4   <= q_s3;
			cur_s4 <= cur_s3;
		end
		if (adv[5]) begin
			cur_s5 <= cur_s4;
		end
		if (adv[6]) begin
			cur_s6 <= cur_s5;
		end
	end

	// stages 5-6: alpha, beta-alpha and 1+alpha*beta scaling, precession plus damping
	llt_scale u_scale (
		.clk     (clk),
		.en      (adv[6:5]),
		.coef    (coef),
		.p       (p_s4),
		.q       (q_s4),
		.d       (d_s4),
		.e       (e_s4),
		.base_s6 (base_s6),
		.s_s6    (s_s6)
	);

	// stages 7-10: current times the spin-torque term, final sum and saturation
	llt_stt u_stt (
		.clk     (clk),
		.en      (adv[10:7]),
		.coef    (coef),
		.base    (base_s6),
		.s       (s_s6),
		.cur     (cur_s6),
		.res_s10 (res_s10)
	);

	assign torque.valid  = stage_vld_q[NSTAGE];
	assign torque.rate_x = res_s10[0];
	assign torque.rate_y = res_s10[1];
	assign torque.rate_z = res_s10[2];

endmodule

[hdl/llt_checker.sv]
module llt_checker #(
	parameter int DEPTH = llt_pkg::NSTAGE
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [llt_pkg::OUT_W-1:0]       rate_x,
	input  logic [llt_pkg::OUT_W-1:0]       rate_y,
	input  logic [llt_pkg::OUT_W-1:0]       rate_z
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0] inflight_q;
	logic             acc_in, acc_out;

	assign acc_in  = in_valid && in_ready;
	assign acc_out = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (acc_in && !acc_out) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (acc_out && !acc_in) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	// never more requests in flight than pipeline stages
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(DEPTH))
		else $error("more requests in flight than stages");

	// input only blocks once every stage holds a request
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> inflight_q == CNT_W'(DEPTH))
		else $error("input blocked with room in the pipeline");

	// no result without a request behind it
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("result with nothing in flight");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rate_x) && $stable(rate_y)
		                          && $stable(rate_z))
		else $error("stalled result changed");

endmodule

bind llg_torque_per_node llt_checker u_llt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (node.valid),
	.in_ready  (node.ready),
	.out_valid (torque.valid),
	.out_ready (torque.ready),
	.rate_x    (torque.rate_x),
	.rate_y    (torque.rate_y),
	.rate_z    (torque.rate_z)
);
